[hdl/twdtw_pkg.sv]
package twdtw_pkg;

    localparam int NUM_BANDS = 4;
    localparam int BAND_W    = 16;
    localparam int TIME_W    = 10;
    localparam int COST_W    = 32;
    localparam int COL_W     = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_SERIES = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_CYC_PERIOD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BETA_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_COUNT  = 3'd4;

    localparam logic [COST_W-1:0] COST_UNREACH = 32'hFFFF_FFFF;
    localparam logic [COST_W-1:0] COST_TOP     = 32'hFFFF_FFFE;
    localparam logic [12:0]       LOGISTIC_ONE = 13'd4096;

    typedef struct packed {
        logic [1:0]               opcode;
        logic [TIME_W-1:0]        sample_time;
        logic signed [BAND_W-1:0] band_a;
        logic signed [BAND_W-1:0] band_b;
        logic signed [BAND_W-1:0] band_c;
        logic signed [BAND_W-1:0] band_d;
    } item_t;

    typedef struct packed {
        logic [COL_W-1:0]  column_index;
        logic [COST_W-1:0] last_cost;
        logic              origin_valid;
        logic [COL_W-1:0]  origin_column;
        logic              match_valid;
        logic [COL_W-1:0]  match_column;
        logic [COST_W-1:0] match_cost;
    } result_t;

    typedef struct packed {
        logic [9:0]  cyc_period;
        logic [9:0]  gap_limit;
        logic [15:0] alpha_gain;
        logic [9:0]  beta_offset;
        logic [2:0]  band_count;
    } cfg_t;

    function automatic logic [12:0] logistic_tab(input logic [4:0] idx);
        logic [12:0] v;
        case (idx)
            5'd0:    v = 13'd2048;
            5'd1:    v = 13'd2550;
            5'd2:    v = 13'd2994;
            5'd3:    v = 13'd3349;
            5'd4:    v = 13'd3608;
            5'd5:    v = 13'd3785;
            5'd6:    v = 13'd3902;
            5'd7:    v = 13'd3976;
            5'd8:    v = 13'd4022;
            5'd9:    v = 13'd4051;
            5'd10:   v = 13'd4069;
            5'd11:   v = 13'd4079;
            5'd12:   v = 13'd4086;
            5'd13:   v = 13'd4090;
            5'd14:   v = 13'd4092;
            5'd15:   v = 13'd4094;
            5'd16:   v = 13'd4095;
            5'd17:   v = 13'd4095;
            5'd18:   v = 13'd4095;
            default: v = 13'd4096;
        endcase
        return v;
    endfunction

    function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] acc,
                                                  input logic [17:0] lc);
        logic [COST_W:0] s;
        s = {1'b0, acc} + {15'd0, lc};
        if (acc == COST_UNREACH)
            return COST_UNREACH;
        else if (s > {1'b0, COST_TOP})
            return COST_TOP;
        else
            return s[COST_W-1:0];
    endfunction

endpackage

[hdl/twdtw_front.sv]
module twdtw_front import twdtw_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    output logic  item_stall,
    input  item_t item,
    output logic  q_valid,
    input  logic  q_pop,
    output item_t q_item
);

    item_t      buf_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;

    assign item_stall = (count_reg == 2'd2);
    assign push       = item_valid && !item_stall;
    assign q_valid    = (count_reg != 2'd0);
    assign q_item     = buf_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop && q_valid)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, (q_pop && q_valid)};
        end
    end

endmodule

[hdl/twdtw_back.sv]
module twdtw_back import twdtw_pkg::*;
#(
    parameter int PATTERN_MAX = 64,
    parameter int SERIES_MAX  = 65536
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    q_valid,
    output logic    q_pop,
    input  item_t   q_item,
    output logic    res_valid,
    input  logic    res_stall,
    output result_t res
);

    localparam int AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int CW = $clog2(PATTERN_MAX + 1);
    localparam int JW = $clog2(SERIES_MAX) + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_PRE, S_SQ, S_SQRT, S_CELL, S_GROUP, S_OUT
    } state_t;

    logic [TIME_W-1:0]          ptime_mem [PATTERN_MAX];
    logic [NUM_BANDS*BAND_W-1:0] pband_mem [PATTERN_MAX];
    logic [COST_W-1:0]          cost_mem  [PATTERN_MAX];
    logic [COL_W:0]             org_mem   [PATTERN_MAX];

    logic [TIME_W-1:0]           pt_q;
    logic [NUM_BANDS*BAND_W-1:0] pb_q;
    logic [COST_W-1:0]           cc_q;
    logic [COL_W:0]              co_q;

    state_t            state_reg;
    item_t             item_reg;
    logic [CW-1:0]     pat_cnt_reg;
    logic [JW-1:0]     col_cnt_reg;
    logic [AW-1:0]     row_reg;
    logic              group_open_reg;
    logic [COL_W-1:0]  group_origin_reg;
    logic [COL_W-1:0]  best_col_reg;
    logic [COST_W-1:0] best_cost_reg;
    logic [COST_W-1:0] up_c_reg;
    logic [COL_W:0]    up_o_reg;
    logic [COST_W-1:0] dg_c_reg;
    logic [COL_W:0]    dg_o_reg;
    logic signed [11:0] dt_reg;
    logic              e_neg_reg;
    logic [11:0]       mag_reg;
    logic [27:0]       z_reg;
    logic [1:0]        k_reg;
    logic [33:0]       sq_reg;
    logic [34:0]       rem_reg;
    logic [34:0]       root_reg;
    logic [4:0]        step_reg;
    logic [12:0]       lg_reg;
    result_t           pend_reg;
    result_t           res_reg;
    logic              res_valid_reg;

    logic               load_wr;
    logic [9:0]         d_abs;
    logic signed [11:0] c_gap;
    logic signed [11:0] dt_w;
    logic signed [12:0] e_w;
    logic [2:0]         nb;
    logic signed [16:0] diff;
    logic signed [33:0] diff_sq;
    logic [33:0]        sq_next;
    logic [15:0]        pband_k;
    logic [15:0]        xband_k;
    logic [34:0]        bitv;
    logic [34:0]        trial;
    logic [16:0]        zi;
    logic [10:0]        zf;
    logic [12:0]        lg_a;
    logic [12:0]        lg_b;
    logic [23:0]        lg_prod;
    logic [12:0]        lg_w;
    logic [12:0]        lg_s;
    logic [17:0]        lc;
    logic [COST_W-1:0]  t_dg;
    logic [COST_W-1:0]  t_lf;
    logic [COST_W-1:0]  t_up;
    logic [COST_W-1:0]  cell_c;
    logic [COL_W:0]     cell_o;
    logic [COL_W-1:0]   j16;
    logic               last_row;
    logic               grp_new;
    logic               grp_close;

    assign q_pop     = (state_reg == S_IDLE) && q_valid;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign load_wr   = q_pop && (q_item.opcode == OP_LOAD)
                       && (pat_cnt_reg < CW'(PATTERN_MAX));
    assign j16       = COL_W'(col_cnt_reg);
    assign last_row  = (CW'(row_reg) + CW'(1)) == pat_cnt_reg;

    always_ff @(posedge clk)
    begin
        if (load_wr)
        begin
            ptime_mem[pat_cnt_reg[AW-1:0]] <= q_item.sample_time;
            pband_mem[pat_cnt_reg[AW-1:0]] <= {q_item.band_d, q_item.band_c,
                                               q_item.band_b, q_item.band_a};
        end
        if (state_reg == S_CELL)
        begin
            cost_mem[row_reg] <= cell_c;
            org_mem[row_reg]  <= cell_o;
        end
        pt_q <= ptime_mem[row_reg];
        pb_q <= pband_mem[row_reg];
        cc_q <= cost_mem[row_reg];
        co_q <= org_mem[row_reg];
    end

    always_comb
    begin
        d_abs = (pt_q >= item_reg.sample_time) ? (pt_q - item_reg.sample_time)
                                               : (item_reg.sample_time - pt_q);
        c_gap = $signed({2'b00, cfg.cyc_period}) - $signed({2'b00, d_abs});
        dt_w  = (c_gap < $signed({2'b00, d_abs})) ? c_gap : $signed({2'b00, d_abs});
        e_w   = 13'(dt_w) - $signed({3'b000, cfg.beta_offset});

        nb      = (cfg.band_count > 3'(NUM_BANDS)) ? 3'(NUM_BANDS) : cfg.band_count;
        pband_k = pb_q[k_reg*BAND_W +: BAND_W];
        case (k_reg)
            2'd0:    xband_k = item_reg.band_a;
            2'd1:    xband_k = item_reg.band_b;
            2'd2:    xband_k = item_reg.band_c;
            default: xband_k = item_reg.band_d;
        endcase
        diff    = $signed({pband_k[15], pband_k}) - $signed({xband_k[15], xband_k});
        diff_sq = diff * diff;
        sq_next = sq_reg + ((({1'b0, k_reg}) < nb) ? $unsigned(diff_sq) : 34'd0);

        bitv  = 35'd1 << {(5'd17 - step_reg), 1'b0};
        trial = root_reg + bitv;

        zi      = z_reg[27:11];
        zf      = z_reg[10:0];
        lg_a    = logistic_tab(zi[4:0]);
        lg_b    = logistic_tab(zi[4:0] + 5'd1);
        lg_prod = (lg_b - lg_a) * zf;
        lg_w    = (zi >= 17'd19) ? LOGISTIC_ONE : (lg_a + 13'(lg_prod >> 11));

        lg_s = e_neg_reg ? (LOGISTIC_ONE - lg_reg) : lg_reg;
        lc   = 18'(root_reg[16:0]) + 18'(lg_s);
        t_dg = sat_add(dg_c_reg, lc);
        t_lf = sat_add(cc_q, lc);
        t_up = sat_add(up_c_reg, lc);
        if (col_cnt_reg == '0)
        begin
            cell_c = t_up;
            cell_o = {1'b1, {COL_W{1'b0}}};
        end
        else if (dt_reg > $signed({2'b00, cfg.gap_limit}))
        begin
            cell_c = COST_UNREACH;
            cell_o = '0;
        end
        else
        begin
            cell_c = t_dg;
            cell_o = dg_o_reg;
            if (t_lf < cell_c)
            begin
                cell_c = t_lf;
                cell_o = co_q;
            end
            if (t_up < cell_c)
            begin
                cell_c = t_up;
                cell_o = up_o_reg;
            end
        end

        grp_new   = up_o_reg[COL_W]
                    && (!group_open_reg || (up_o_reg[COL_W-1:0] != group_origin_reg));
        grp_close = grp_new && group_open_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            item_reg         <= '0;
            pat_cnt_reg      <= '0;
            col_cnt_reg      <= '0;
            row_reg          <= '0;
            group_open_reg   <= 1'b0;
            group_origin_reg <= '0;
            best_col_reg     <= '0;
            best_cost_reg    <= '0;
            up_c_reg         <= '0;
            up_o_reg         <= '0;
            dg_c_reg         <= '0;
            dg_o_reg         <= '0;
            dt_reg           <= '0;
            e_neg_reg        <= 1'b0;
            mag_reg          <= '0;
            z_reg            <= '0;
            k_reg            <= '0;
            sq_reg           <= '0;
            rem_reg          <= '0;
            root_reg         <= '0;
            step_reg         <= '0;
            lg_reg           <= '0;
            pend_reg         <= '0;
            res_reg          <= '0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            if (res_valid_reg && !res_stall && (state_reg != S_OUT))
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        item_reg <= q_item;
                        unique case (q_item.opcode)
                            OP_LOAD:
                            begin
                                col_cnt_reg    <= '0;
                                group_open_reg <= 1'b0;
                                if (load_wr)
                                begin
                                    pat_cnt_reg <= pat_cnt_reg + CW'(1);
                                end
                            end
                            OP_CLEAR:
                            begin
                                col_cnt_reg    <= '0;
                                group_open_reg <= 1'b0;
                                pat_cnt_reg    <= '0;
                            end
                            OP_FLUSH:
                            begin
                                col_cnt_reg    <= '0;
                                group_open_reg <= 1'b0;
                                if (group_open_reg)
                                begin
                                    pend_reg  <= '{column_index: '0, last_cost: '0,
                                                   origin_valid: 1'b0, origin_column: '0,
                                                   match_valid: 1'b1,
                                                   match_column: best_col_reg,
                                                   match_cost: best_cost_reg};
                                    state_reg <= S_OUT;
                                end
                            end
                            default:
                            begin
                                if (col_cnt_reg < JW'(SERIES_MAX))
                                begin
                                    row_reg  <= '0;
                                    up_c_reg <= '0;
                                    up_o_reg <= {1'b1, j16};
                                    dg_c_reg <= '0;
                                    dg_o_reg <= {1'b1, j16 - COL_W'(1)};
                                    state_reg <= (pat_cnt_reg == '0) ? S_GROUP : S_RD;
                                end
                            end
                        endcase
                    end
                end
                S_RD:
                begin
                    state_reg <= S_PRE;
                end
                S_PRE:
                begin
                    dt_reg    <= dt_w;
                    e_neg_reg <= e_w[12];
                    mag_reg   <= e_w[12] ? 12'(-e_w) : 12'(e_w);
                    k_reg     <= '0;
                    sq_reg    <= '0;
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    z_reg  <= cfg.alpha_gain * mag_reg;
                    sq_reg <= sq_next;
                    k_reg  <= k_reg + 2'd1;
                    if (k_reg == 2'd3)
                    begin
                        rem_reg   <= {1'b0, sq_next};
                        root_reg  <= '0;
                        step_reg  <= '0;
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    lg_reg <= lg_w;
                    if (rem_reg >= trial)
                    begin
                        rem_reg  <= rem_reg - trial;
                        root_reg <= (root_reg >> 1) + bitv;
                    end
                    else
                    begin
                        root_reg <= root_reg >> 1;
                    end
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'd17)
                    begin
                        state_reg <= S_CELL;
                    end
                end
                S_CELL:
                begin
                    dg_c_reg <= cc_q;
                    dg_o_reg <= co_q;
                    up_c_reg <= cell_c;
                    up_o_reg <= cell_o;
                    if (last_row)
                    begin
                        state_reg <= S_GROUP;
                    end
                    else
                    begin
                        row_reg   <= row_reg + AW'(1);
                        state_reg <= S_RD;
                    end
                end
                S_GROUP:
                begin
                    col_cnt_reg <= col_cnt_reg + JW'(1);
                    pend_reg    <= '{column_index: j16, last_cost: up_c_reg,
                                     origin_valid: up_o_reg[COL_W],
                                     origin_column: up_o_reg[COL_W] ? up_o_reg[COL_W-1:0]
                                                                    : '0,
                                     match_valid: grp_close,
                                     match_column: grp_close ? best_col_reg : '0,
                                     match_cost: grp_close ? best_cost_reg : '0};
                    if (grp_new)
                    begin
                        group_open_reg   <= 1'b1;
                        group_origin_reg <= up_o_reg[COL_W-1:0];
                        best_col_reg     <= j16;
                        best_cost_reg    <= up_c_reg;
                    end
                    else if (up_o_reg[COL_W] && (up_c_reg < best_cost_reg))
                    begin
                        best_col_reg  <= j16;
                        best_cost_reg <= up_c_reg;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!res_valid_reg || !res_stall)
                    begin
                        res_reg       <= pend_reg;
                        res_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[hdl/time_weighted_dtw_open_begin.sv]
// Series transaction: per stored pattern row, a read, a setup step, the
// 4-step band sum, the 18-step square root and a cell update; then grouping.
// Load and clear finish in idle; a flush with an open group emits a match.
// A 2-entry input queue and a result register decouple both channels.
// Asynchronous active-low reset clears control state, counters and registers
// to their defaults; pattern and column memories are undefined until written.
module time_weighted_dtw_open_begin import twdtw_pkg::*;
#(
    parameter int PATTERN_MAX = 64,
    parameter int SERIES_MAX  = 65536
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  item_t                item,
    output logic                 res_valid,
    input  logic                 res_stall,
    output result_t              res,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cfg_t  cfg_reg;
    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cyc_period  <= 10'd365;
            cfg_reg.gap_limit   <= 10'd1023;
            cfg_reg.alpha_gain  <= 16'd410;
            cfg_reg.beta_offset <= 10'd50;
            cfg_reg.band_count  <= 3'd4;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CYC_PERIOD:  cfg_reg.cyc_period  <= cfg_data[9:0];
                REG_GAP_LIMIT:   cfg_reg.gap_limit   <= cfg_data[9:0];
                REG_ALPHA_GAIN:  cfg_reg.alpha_gain  <= cfg_data;
                REG_BETA_OFFSET: cfg_reg.beta_offset <= cfg_data[9:0];
                REG_BAND_COUNT:  cfg_reg.band_count  <= cfg_data[2:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    twdtw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_item     (q_item)
    );

    twdtw_back #(
        .PATTERN_MAX (PATTERN_MAX),
        .SERIES_MAX  (SERIES_MAX)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule
